// ----- hdl/mrks_pkg.sv -----
// Shared types and constants of the maximum-ratio k-subset selector.
`default_nettype none

package mrks_pkg;

  localparam int unsigned VAL_W = 20;
  localparam int unsigned IDX_W = 11;
  localparam int unsigned CFG_W = 7;

  typedef struct packed {
    logic [VAL_W-1:0] item_value;
    logic [VAL_W-1:0] item_weight;
    logic             last_item;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0] chosen_index;
    logic             last_of_run;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_LOAD = 4'b0001,
    ST_SCAN = 4'b0010,
    ST_SUM  = 4'b0100,
    ST_EMIT = 4'b1000
  } state_e;

endpackage

`default_nettype wire

// ----- hdl/max_ratio_k_subset_select_core.sv -----
// Top level of the maximum-ratio k-subset selector: item store, ranking pass and bisection.
`default_nettype none

// Items are loaded one per cycle into an on-chip store until an item marked last_item
// arrives. The block then finds the largest ratio r (Q20.FRAC_BITS, unsigned) for which
// the k largest keys v*2^FRAC_BITS - r*w sum to zero or more, bit by bit from the top,
// and emits the 1-based load positions of the top k items at r in falling key order,
// ties to the lower position. Each bisection trial is one pass over the n stored items
// through the single read port of the store followed by summing the k kept keys; there
// are 20 + FRAC_BITS trials plus one final ranking pass before the k results of a set
// appear. No new item is taken until the last result of a set has been transferred.
module max_ratio_k_subset_select_core
  import mrks_pkg::*;
#(
  parameter int unsigned MAX_ITEMS = 1024,
  parameter int unsigned MAX_PICK  = 64,
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire in_item_t         in_data_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output out_item_t             out_data_o,
  input  wire logic             cfg_we_i,
  input  wire logic [CFG_W-1:0] cfg_wdata_i
);

  localparam int unsigned PW  = $clog2(MAX_ITEMS);
  localparam int unsigned CW  = $clog2(MAX_ITEMS + 1);
  localparam int unsigned KB  = $clog2(MAX_PICK + 1);
  localparam int unsigned RB  = VAL_W + FRAC_BITS;
  localparam int unsigned BB  = $clog2(RB);
  localparam int unsigned PRW = RB + VAL_W;
  localparam int unsigned KW  = PRW + 1;
  localparam int unsigned SW  = KW + KB;
  localparam int unsigned MW  = 2 * VAL_W;

  state_e state_q;

  logic [CFG_W-1:0] pick_q;
  logic [CW-1:0]    items_q;
  logic [CW-1:0]    scan_q;
  logic [KB-1:0]    kk_q;
  logic [RB-1:0]    ratio_q;
  logic [BB-1:0]    bit_q;
  logic             final_q;
  logic [SW-1:0]    sum_q;

  // Item store: value in the upper half, weight in the lower half.
  logic [MW-1:0] mem [MAX_ITEMS];
  logic [MW-1:0] rd_q;

  logic          s1_vld_q, s2_vld_q, s3_vld_q;
  logic [PW-1:0] s1_pos_q, s2_pos_q, s3_pos_q;
  logic [PRW-1:0] prod_q;
  logic [RB-1:0]  vsh_q;
  logic [KW-1:0]  key3_q;

  logic [MAX_PICK-1:0] vld_q;
  logic [KW-1:0]       slot_key_q [MAX_PICK];
  logic [PW-1:0]       slot_pos_q [MAX_PICK];

  logic                in_fire, out_fire, issue, pipe_busy, pass_done, store_room;
  logic [CW-1:0]       n_d;
  logic [CFG_W-1:0]    pk_sat;
  logic [KB-1:0]       kk_d;
  logic [RB-1:0]       trial;
  logic [MAX_PICK-1:0] gt, act;
  logic                do_clear, do_insert, do_shift;

  assign in_ready_o = (state_q == ST_LOAD);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_valid_o = (state_q == ST_EMIT) && vld_q[0];
  assign out_fire   = out_valid_o && out_ready_i;

  assign out_data_o.chosen_index = IDX_W'({1'b0, slot_pos_q[0]} + (PW + 1)'(1));
  assign out_data_o.last_of_run  = (MAX_PICK == 1) ? 1'b1 : ~vld_q[MAX_PICK > 1 ? 1 : 0];

  assign store_room = (items_q < CW'(MAX_ITEMS));
  assign n_d        = store_room ? items_q + CW'(1) : items_q;
  assign pk_sat     = (int'(pick_q) > int'(MAX_PICK)) ? CFG_W'(MAX_PICK) : pick_q;
  assign kk_d       = (int'(pk_sat) > int'(n_d)) ? KB'(n_d) : KB'(pk_sat);

  assign trial     = final_q ? ratio_q : (ratio_q | (RB'(1) << bit_q));
  assign issue     = (state_q == ST_SCAN) && (scan_q != items_q);
  assign pipe_busy = s1_vld_q || s2_vld_q || s3_vld_q;
  assign pass_done = (state_q == ST_SCAN) && (scan_q == items_q) && !pipe_busy;

  assign do_clear  = (in_fire && in_data_i.last_item) ||
                     ((state_q == ST_SUM) && !vld_q[0]);
  assign do_insert = (state_q == ST_SCAN) && s3_vld_q;
  assign do_shift  = ((state_q == ST_SUM) && vld_q[0]) || out_fire;

  // Keys in the list are sorted downward and empty slots trail, so gt is a thermometer.
  always_comb begin
    for (int i = 0; i < MAX_PICK; i++) begin
      act[i] = (i < int'(kk_q));
      gt[i]  = act[i] && (!vld_q[i] || ($signed(key3_q) > $signed(slot_key_q[i])));
    end
  end

  // Loading and scanning never overlap, so the store needs no forwarding.
  always_ff @(posedge clk_i) begin
    if (in_fire && store_room) begin
      mem[items_q[PW-1:0]] <= {in_data_i.item_value, in_data_i.item_weight};
    end
    if (issue) begin
      rd_q <= mem[scan_q[PW-1:0]];
    end
  end

  // Key pipeline: read, multiply, subtract.
  always_ff @(posedge clk_i) begin
    s1_pos_q <= scan_q[PW-1:0];
    s2_pos_q <= s1_pos_q;
    s3_pos_q <= s2_pos_q;
    prod_q   <= PRW'(trial) * PRW'(rd_q[VAL_W-1:0]);
    vsh_q    <= {rd_q[MW-1:VAL_W], {FRAC_BITS{1'b0}}};
    key3_q   <= KW'(vsh_q) - KW'(prod_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= issue;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (do_clear) begin
      vld_q <= '0;
    end else if (do_insert) begin
      for (int i = 0; i < MAX_PICK; i++) begin
        if (gt[i]) begin
          vld_q[i] <= (i > 0 && gt[i > 0 ? i - 1 : 0]) ? vld_q[i > 0 ? i - 1 : 0] : 1'b1;
        end
      end
    end else if (do_shift) begin
      for (int i = 0; i < MAX_PICK; i++) begin
        vld_q[i] <= (i + 1 < MAX_PICK) ? vld_q[i + 1 < MAX_PICK ? i + 1 : i] : 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_insert) begin
      for (int i = 0; i < MAX_PICK; i++) begin
        if (gt[i]) begin
          if (i > 0 && gt[i > 0 ? i - 1 : 0]) begin
            slot_key_q[i] <= slot_key_q[i > 0 ? i - 1 : 0];
            slot_pos_q[i] <= slot_pos_q[i > 0 ? i - 1 : 0];
          end else begin
            slot_key_q[i] <= key3_q;
            slot_pos_q[i] <= s3_pos_q;
          end
        end
      end
    end else if (do_shift) begin
      for (int i = 0; i + 1 < MAX_PICK; i++) begin
        slot_key_q[i] <= slot_key_q[i + 1];
        slot_pos_q[i] <= slot_pos_q[i + 1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      pick_q  <= CFG_W'(1);
      items_q <= '0;
      scan_q  <= '0;
      kk_q    <= '0;
      ratio_q <= '0;
      bit_q   <= '0;
      final_q <= 1'b0;
      sum_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        pick_q <= cfg_wdata_i;
      end
      if (issue) begin
        scan_q <= scan_q + CW'(1);
      end
      case (state_q)
        ST_LOAD: begin
          if (in_fire) begin
            items_q <= n_d;
            if (in_data_i.last_item) begin
              kk_q    <= kk_d;
              ratio_q <= '0;
              bit_q   <= BB'(RB - 1);
              final_q <= 1'b0;
              scan_q  <= '0;
              state_q <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (pass_done) begin
            sum_q   <= '0;
            state_q <= final_q ? ST_EMIT : ST_SUM;
          end
        end
        ST_SUM: begin
          if (vld_q[0]) begin
            sum_q <= sum_q + SW'($signed(slot_key_q[0]));
          end else begin
            // A trial is kept when the top-k key sum is not negative.
            if (!sum_q[SW-1]) begin
              ratio_q <= trial;
            end
            if (bit_q == '0) begin
              final_q <= 1'b1;
            end else begin
              bit_q <= bit_q - BB'(1);
            end
            scan_q  <= '0;
            state_q <= ST_SCAN;
          end
        end
        ST_EMIT: begin
          if (!vld_q[0]) begin
            items_q <= '0;
            state_q <= ST_LOAD;
          end
        end
        default: begin
          state_q <= ST_LOAD;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // The ranked list always fills from the top without gaps.
  a_list_packed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (MAX_PICK'(vld_q + MAX_PICK'(1)) & vld_q) == '0)
    else $error("ranked list has a gap");

  // The list never holds more entries than the pick count allows.
  a_list_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(vld_q) <= int'(kk_q))
    else $error("ranked list exceeds pick count");

  // Nothing is in flight in the key pipeline while items are being loaded.
  a_pipe_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !(s1_vld_q || s2_vld_q || s3_vld_q))
    else $error("key pipeline busy during loading");

  // After the final result of a set the block returns to loading.
  a_run_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_fire && out_data_o.last_of_run) |=> ##1 (state_q == ST_LOAD))
    else $error("block did not return to loading after a run");
`endif

endmodule

`default_nettype wire
